// ----- sv/gbt_pkg.sv -----
package gbt_pkg;

  // Message framing constants
  localparam logic [7:0]  MARKER_BYTE   = 8'h40;
  localparam logic [15:0] TIME_CMD      = 16'h4561;
  localparam int          TIME_FIELDS   = 7;
  localparam int          PAYLOAD_BYTES = 70;
  localparam int          BUFFER_BYTES  = 72;

  // Parser states
  typedef enum logic [2:0] {
    ST_WAIT = 3'd0,
    ST_AT1  = 3'd1,
    ST_AT2  = 3'd2,
    ST_CMD1 = 3'd3,
    ST_COPY = 3'd4
  } parse_state_t;

  // Per-byte status codes
  typedef enum logic [1:0] {
    STAT_IDLE   = 2'd0,
    STAT_BUSY   = 2'd1,
    STAT_REJECT = 2'd2,
    STAT_DONE   = 2'd3
  } status_t;

  // One result transaction
  typedef struct packed {
    status_t     status;
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } result_t;

endpackage

// ----- sv/gbt_parse_core.sv -----
module gbt_parse_core #(
  parameter int PAYLOAD_BYTES = gbt_pkg::PAYLOAD_BYTES,
  parameter int BUFFER_BYTES  = gbt_pkg::BUFFER_BYTES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       data_byte,
  output gbt_pkg::result_t result
);
  import gbt_pkg::*;

  localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int IDX_W = $clog2(TIME_FIELDS);
  localparam bit FITS  = (PAYLOAD_BYTES <= BUFFER_BYTES);

  parse_state_t state;
  parse_state_t state_next;
  logic [7:0]   cmd_hi;
  logic [7:0]   cmd_hi_next;
  logic [7:0]   csum;
  logic [7:0]   csum_next;
  logic [CNT_W-1:0] bytes_left;
  logic [CNT_W-1:0] bytes_left_next;
  logic [CNT_W-1:0] idx;
  logic         tb_we;
  logic [7:0]   time_bytes [TIME_FIELDS];

  logic         cmd_ok;
  logic         last_byte;
  logic [7:0]   csum_fold;

  assign idx       = CNT_W'(PAYLOAD_BYTES) - bytes_left;
  assign cmd_ok    = ({cmd_hi, data_byte} == TIME_CMD) && FITS;
  assign last_byte = (bytes_left <= CNT_W'(1));
  assign csum_fold = csum ^ data_byte;

  // Next state
  always_comb begin
    case (state)
      ST_WAIT: state_next = (data_byte == MARKER_BYTE) ? ST_AT1 : ST_WAIT;
      ST_AT1:  state_next = (data_byte == MARKER_BYTE) ? ST_AT2 : ST_WAIT;
      ST_AT2:  state_next = ST_CMD1;
      ST_CMD1: state_next = cmd_ok ? ST_COPY : ST_WAIT;
      ST_COPY: state_next = last_byte ? ST_WAIT : ST_COPY;
      default: state_next = ST_WAIT;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    result          = '0;
    result.status   = STAT_REJECT;
    cmd_hi_next     = cmd_hi;
    csum_next       = csum;
    bytes_left_next = bytes_left;
    tb_we           = 1'b0;
    case (state)
      ST_WAIT: begin
        result.status = (data_byte == MARKER_BYTE) ? STAT_BUSY : STAT_IDLE;
      end
      ST_AT1: begin
        result.status = STAT_BUSY;
      end
      ST_AT2: begin
        cmd_hi_next   = data_byte;
        csum_next     = data_byte;
        result.status = STAT_BUSY;
      end
      ST_CMD1: begin
        cmd_hi_next = data_byte;
        csum_next   = csum_fold;
        if (cmd_ok) begin
          bytes_left_next = CNT_W'(PAYLOAD_BYTES);
          result.status   = STAT_BUSY;
        end else begin
          result.status = STAT_REJECT;
        end
      end
      ST_COPY: begin
        csum_next = csum_fold;
        tb_we     = (idx < CNT_W'(TIME_FIELDS));
        if (!last_byte) begin
          bytes_left_next = bytes_left - CNT_W'(1);
          result.status   = STAT_BUSY;
        end else begin
          bytes_left_next = '0;
          if (csum_fold != 8'd0) begin
            result.status = STAT_REJECT;
          end else begin
            result.status = STAT_DONE;
            result.year   = {time_bytes[2], time_bytes[3]};
            result.month  = time_bytes[0];
            result.day    = time_bytes[1];
            result.hour   = time_bytes[4];
            result.minute = time_bytes[5];
            result.second = time_bytes[6];
          end
        end
      end
      default: begin
        result.status = STAT_REJECT;
      end
    endcase
  end

  // Advance parser state on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_WAIT;
      cmd_hi     <= '0;
      csum       <= '0;
      bytes_left <= '0;
    end else if (advance) begin
      state      <= state_next;
      cmd_hi     <= cmd_hi_next;
      csum       <= csum_next;
      bytes_left <= bytes_left_next;
    end
  end

  // Capture the leading time bytes
  always_ff @(posedge clk) begin
    if (advance && tb_we) begin
      time_bytes[idx[IDX_W-1:0]] <= data_byte;
    end
  end

endmodule

// ----- sv/gps_binary_time_message_parser.sv -----
// A byte accepted passes through the input register, then the result register.
// Throughput: one byte per cycle unless out_stall holds a full result register;
// only the combinational parser state update sits between the two registers.
// Reset: synchronous active-high rst returns the parser to waiting for a marker
// and empties both register stages.
module gps_binary_time_message_parser #(
  parameter int PAYLOAD_BYTES = gbt_pkg::PAYLOAD_BYTES,
  parameter int BUFFER_BYTES  = gbt_pkg::BUFFER_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] year,
  output logic [7:0]  month,
  output logic [7:0]  day,
  output logic [7:0]  hour,
  output logic [7:0]  minute,
  output logic [7:0]  second
);
  import gbt_pkg::*;

  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       accept;
  logic       advance;
  result_t    result;

  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Hold the incoming byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (accept) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg_byte <= data_byte;
    end
  end

  gbt_parse_core #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .BUFFER_BYTES  (BUFFER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data_byte (in_reg_byte),
    .result    (result)
  );

  // Register the result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status <= result.status;
      year   <= result.year;
      month  <= result.month;
      day    <= result.day;
      hour   <= result.hour;
      minute <= result.minute;
      second <= result.second;
    end
  end

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_reg_valid && out_valid && out_stall))
    else $error("input stalled while the result register could take data");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced transaction did not reach the result register");

  a_time_zero_unless_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STAT_DONE) |->
      (year == 16'd0 && month == 8'd0 && day == 8'd0 &&
       hour == 8'd0 && minute == 8'd0 && second == 8'd0))
    else $error("time fields nonzero on a result that is not complete");
`endif

endmodule
